// ===== design/four_level_page_map_builder_defines.svh =====
// ----------------------------------------------------------------------------
// Page map builder assertion macros
// Shared property wrappers; each expects clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_MAP_BUILDER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_MAP_BUILDER_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define PMB_CHECK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle
`define PMB_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the following cycle
`define PMB_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Page map builder package
// Sizes, status codes, controller states and command/status words.
// ----------------------------------------------------------------------------
`default_nettype none

package pmb_pkg;

  // Table store geometry
  localparam int TABLE_FRAMES = 16;
  localparam int IDX_W        = 9;
  localparam int FRAME_W      = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int ADDR_W       = FRAME_W + IDX_W;
  localparam int DEPTH        = TABLE_FRAMES * (1 << IDX_W);
  localparam int NFF_W        = $clog2(TABLE_FRAMES + 1);

  // Address and entry layout
  localparam int VADDR_W   = 64;
  localparam int PADDR_W   = 52;
  localparam int PAGE_W    = 12;
  localparam int PFN_W     = PADDR_W - PAGE_W;
  localparam int ENTRY_W   = 64;
  localparam int LEVELS    = 4;
  localparam int VPN_W     = LEVELS * IDX_W;
  localparam logic [PAGE_W-1:0] ENTRY_FLAGS = 12'h003;  // present and writeable

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_NO_FRAMES = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FILL,
    ST_LINK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    sweep;
    logic    rd;
    logic    alloc;
    logic    fill;
    logic    link;
    logic    descend;
    logic    leaf;
    logic    finish;
    status_t code;
  } pmb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic misaligned;
    logic present;
    logic pool_empty;
    logic in_range;
    logic is_leaf;
    logic sweep_last;
    logic fill_last;
  } pmb_sts_t;

endpackage

`default_nettype wire

// ===== design/pmb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pmb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/pmb_dpath.sv =====
// ----------------------------------------------------------------------------
// Page map builder datapath
// Table store, walk registers, frame allocator and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_level_page_map_builder_defines.svh"

module pmb_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [pmb_pkg::PADDR_W-1:0] cfg_data,
  input  wire logic [pmb_pkg::VADDR_W-1:0] page_start,
  input  wire logic [pmb_pkg::PADDR_W-1:0] frame_start,
  input  wire pmb_pkg::pmb_cmd_t         cmd,
  output pmb_pkg::pmb_sts_t              sts,
  output logic                           done,
  output logic [1:0]                     status
);
  import pmb_pkg::*;

  logic [PFN_W-1:0]            base_pfn;
  logic [LEVELS-1:0][IDX_W-1:0] vpn;
  logic [PFN_W-1:0]            frame_pfn;
  logic [1:0]                  level;
  logic [FRAME_W-1:0]          cur_table;
  logic [FRAME_W-1:0]          fresh;
  logic [NFF_W-1:0]            nff;
  logic [ADDR_W-1:0]           clr_cnt;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [ENTRY_W-1:0]          ram_wdata;
  logic [ADDR_W-1:0]           slot;
  logic [ENTRY_W-1:0]          rdata;
  logic [PFN_W-1:0]            rel;
  logic [PFN_W-1:0]            fresh_pfn;

  // Base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_pfn <= '0;
    end else if (cfg_write) begin
      base_pfn <= cfg_data[PADDR_W-1:PAGE_W];
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vpn       <= page_start[PAGE_W+VPN_W-1:PAGE_W];
      frame_pfn <= frame_start[PADDR_W-1:PAGE_W];
    end
  end

  // Walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level     <= 2'd3;
      cur_table <= '0;
    end else if (cmd.link) begin
      level     <= level - 2'd1;
      cur_table <= fresh;
    end else if (cmd.descend) begin
      level     <= level - 2'd1;
      cur_table <= rel[FRAME_W-1:0];
    end
  end

  // Bump allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      nff <= NFF_W'(1);
    end else if (cmd.alloc) begin
      nff <= nff + NFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      fresh <= nff[FRAME_W-1:0];
    end
  end

  // Clear counter, shared by the reset sweep and table fills
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.alloc) begin
      clr_cnt <= '0;
    end else if (cmd.sweep || cmd.fill) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Store port muxing
  assign slot      = {cur_table, vpn[level]};
  assign fresh_pfn = base_pfn + PFN_W'(fresh);
  assign rel       = rdata[PADDR_W-1:PAGE_W] - base_pfn;

  always_comb begin
    ram_we    = cmd.sweep | cmd.fill | cmd.link | cmd.leaf;
    ram_waddr = slot;
    ram_wdata = '0;
    if (cmd.sweep) begin
      ram_waddr = clr_cnt;
    end else if (cmd.fill) begin
      ram_waddr = {fresh, clr_cnt[IDX_W-1:0]};
    end else if (cmd.link) begin
      ram_wdata = {{(ENTRY_W-PADDR_W){1'b0}}, fresh_pfn, ENTRY_FLAGS};
    end else if (cmd.leaf) begin
      ram_wdata = {{(ENTRY_W-PADDR_W){1'b0}}, frame_pfn, ENTRY_FLAGS};
    end
  end

  pmb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (slot),
    .rdata (rdata)
  );

  // Status back to the controller
  always_comb begin
    sts.misaligned = (page_start[PAGE_W-1:0] != '0) || (frame_start[PAGE_W-1:0] != '0);
    sts.present    = rdata[0];
    sts.pool_empty = (nff >= NFF_W'(TABLE_FRAMES));
    sts.in_range   = (rel < PFN_W'(TABLE_FRAMES));
    sts.is_leaf    = (level == 2'd0);
    sts.sweep_last = (clr_cnt == ADDR_W'(DEPTH - 1));
    sts.fill_last  = (clr_cnt[IDX_W-1:0] == {IDX_W{1'b1}});
  end

  // Result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= cmd.code;
    end
  end

  `PMB_CHECK(a_nff_bound, nff <= NFF_W'(TABLE_FRAMES), "allocator ran past the pool")
  `PMB_NEXT(a_alloc_bump, cmd.alloc, nff == $past(nff) + NFF_W'(1), "allocation lost")
  `PMB_CHECK(a_port_split, !(ram_we && cmd.rd), "store read and write in one cycle")

endmodule

`default_nettype wire

// ===== design/pmb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page map builder controller
// Sequences the reset sweep, the table walk, table fills and the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_level_page_map_builder_defines.svh"

module pmb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pmb_pkg::pmb_sts_t sts,
  output pmb_pkg::pmb_cmd_t      cmd,
  output logic                   busy
);
  import pmb_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && !sts.misaligned) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.is_leaf) begin
          state_next = ST_IDLE;
        end else if (!sts.present) begin
          state_next = sts.pool_empty ? ST_IDLE : ST_FILL;
        end else begin
          state_next = sts.in_range ? ST_READ : ST_IDLE;
        end
      end
      ST_FILL: begin
        if (sts.fill_last) begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        state_next = ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.code = STATUS_OK;
    busy     = (state != ST_IDLE);
    case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      ST_IDLE: begin
        cmd.load   = start;
        cmd.finish = start && sts.misaligned;
        cmd.code   = STATUS_INVALID;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_EVAL: begin
        if (sts.is_leaf) begin
          cmd.finish = 1'b1;
          cmd.leaf   = !sts.present;
          cmd.code   = sts.present ? STATUS_INVALID : STATUS_OK;
        end else if (!sts.present) begin
          cmd.finish = sts.pool_empty;
          cmd.alloc  = !sts.pool_empty;
          cmd.code   = STATUS_NO_FRAMES;
        end else begin
          cmd.descend = sts.in_range;
          cmd.finish  = !sts.in_range;
          cmd.code    = STATUS_INVALID;
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
      end
      ST_LINK: begin
        cmd.link = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `PMB_NEXT(a_finish_idle, cmd.finish, state == ST_IDLE, "result given without return to idle")
  `PMB_IMPLIES(a_sweep_quiet, state == ST_SWEEP, !cmd.finish && !cmd.load,
               "request handled during store sweep")
  `PMB_NEXT(a_fill_link, (state == ST_FILL) && sts.fill_last, state == ST_LINK,
            "table fill not followed by link")

endmodule

`default_nettype wire

// ===== design/four_level_page_map_builder.sv =====
// ----------------------------------------------------------------------------
// Four-level page map builder
// Maps 4 KiB pages into four-level tables held in an internal frame store.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to map page_start to frame_start. After reset
// the block clears its table store, one entry a cycle, and holds busy high
// until the sweep is done. A request walks four table levels, each one store
// read (ST_READ) followed by an evaluation (ST_EVAL); a misaligned request
// reports on done in the cycle after it is taken. Each missing table is
// cleared entry by entry through the single store write port and then linked.
// done is high for exactly one cycle with status valid, and the receiver
// cannot hold it off. Write table_base through cfg_write and cfg_data only
// while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_map_builder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [pmb_pkg::PADDR_W-1:0] cfg_data,
  input  wire logic                        start,
  input  wire logic [pmb_pkg::VADDR_W-1:0] page_start,
  input  wire logic [pmb_pkg::PADDR_W-1:0] frame_start,
  output logic                             busy,
  output logic                             done,
  output logic [1:0]                       status
);
  import pmb_pkg::*;

  pmb_cmd_t cmd;
  pmb_sts_t sts;

  // Sequencer
  pmb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Store and walk datapath
  pmb_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .page_start  (page_start),
    .frame_start (frame_start),
    .cmd         (cmd),
    .sts         (sts),
    .done        (done),
    .status      (status)
  );

endmodule

`default_nettype wire

// ===== dv/tb_four_level_page_map_builder.sv =====
// ----------------------------------------------------------------------------
// Four-level page map builder testbench
// Drives map requests through the start/busy handshake and checks each
// status word on done against a shadow copy of the frame store. The shadow
// walks the same four table levels with its own bump allocator. Directed
// requests cover fresh and shared walks, ignored upper address bits,
// misalignment, relocation of table_base and running out of frames. Random
// traffic with mostly aligned addresses over a few shared paths follows,
// under several table_base settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_four_level_page_map_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import pmb_pkg::*;

  localparam int                 CYCLE_LIMIT  = 400000;
  localparam int                 DRAIN_CYCLES = 16;
  localparam int                 PRESENT_BIT  = 0;
  localparam int                 TABLE_SIZE   = 1 << IDX_W;
  localparam logic [PADDR_W-1:0] MAX_BASE     = 52'hF_FFFF_FFFF_F000;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [PADDR_W-1:0] cfg_data;
  logic               start;
  logic [VADDR_W-1:0] page_start;
  logic [PADDR_W-1:0] frame_start;
  logic               busy;
  logic               done;
  logic [1:0]         status;

  // Shadow of the table store, allocator and table_base
  logic [ENTRY_W-1:0] shadow_store [DEPTH];
  int unsigned        shadow_next;
  logic [PADDR_W-1:0] shadow_base;

  status_t     pending_status [$];
  status_t     expected_status;
  int unsigned errors      = 0;
  int unsigned count_ok    = 0;
  int unsigned count_inval = 0;
  int unsigned count_nofr  = 0;
  int unsigned base_writes = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps     = 1'b0;

  four_level_page_map_builder DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .start      (start),
    .page_start (page_start),
    .frame_start(frame_start),
    .busy       (busy),
    .done       (done),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Walk the shadow tables for one request and update them as the block would
  function automatic status_t predict_map(input logic [VADDR_W-1:0] page,
                                          input logic [PADDR_W-1:0] frame);
    int unsigned        tbl;
    int unsigned        slot;
    int                 lvl;
    int                 i;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] ent;
    logic [PFN_W-1:0]   rel;
    tbl = 0;
    if (page[PAGE_W-1:0] != '0 || frame[PAGE_W-1:0] != '0) return STATUS_INVALID;
    for (lvl = LEVELS - 1; lvl >= 1; lvl--) begin
      idx  = page[PAGE_W + IDX_W*lvl +: IDX_W];
      slot = tbl * TABLE_SIZE + int'(idx);
      ent  = shadow_store[slot];
      if (!ent[PRESENT_BIT]) begin
        if (shadow_next >= TABLE_FRAMES) return STATUS_NO_FRAMES;
        // Clear the fresh table and link it, pointer taken modulo 2^40
        for (i = 0; i < TABLE_SIZE; i++) shadow_store[shadow_next*TABLE_SIZE + i] = '0;
        ent = '0;
        ent[PADDR_W-1:PAGE_W] = shadow_base[PADDR_W-1:PAGE_W] + PFN_W'(shadow_next);
        ent[PAGE_W-1:0]       = ENTRY_FLAGS;
        shadow_store[slot]    = ent;
        shadow_next++;
      end
      rel = ent[PADDR_W-1:PAGE_W] - shadow_base[PADDR_W-1:PAGE_W];
      if (rel >= TABLE_FRAMES) return STATUS_INVALID;
      tbl = int'(rel);
    end
    slot = tbl * TABLE_SIZE + int'(page[PAGE_W +: IDX_W]);
    if (shadow_store[slot][PRESENT_BIT]) return STATUS_INVALID;
    shadow_store[slot] = {{(ENTRY_W-PADDR_W){1'b0}}, frame[PADDR_W-1:PAGE_W], ENTRY_FLAGS};
    return STATUS_OK;
  endfunction

  // Favor a few indices so that walks share tables
  function automatic logic [IDX_W-1:0] pick_table_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5:       return '1;
      6:          return IDX_W'(1);
      7:          return IDX_W'(2);
      8:          return IDX_W'(4);
      default:    return IDX_W'($urandom);
    endcase
  endfunction

  // Present one request word and hold it until the block takes it
  task automatic send_map(input logic [VADDR_W-1:0] page, input logic [PADDR_W-1:0] frame);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    page_start  <= page;
    frame_start <= frame;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_status.push_back(predict_map(page, frame));
    if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
  endtask

  // Drop start and hold until every status word is back and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_table_base(input logic [PADDR_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write   <= 1'b0;
    shadow_base = value;
    base_writes++;
  endtask

  task automatic test_fresh_paths();
    send_map(64'h0000_0000_0000_0000, 52'h0_0000_0000_0000);
    send_map(64'h0000_0000_0000_0000, 52'h0_0000_0000_5000);
    send_map(64'h0000_0000_0000_1000, 52'hF_FFFF_FFFF_F000);
    send_map(64'hFFFF_FFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000);
    // Bits 63:48 do not select a page
    send_map(64'h0000_FFFF_FFFF_F000, 52'h0_0000_0000_1000);
    send_map(64'h8000_0000_0000_0000, 52'h0_0000_0000_2000);
    send_map(64'h0000_0000_0020_0000, 52'h5_5555_5555_5000);
    send_map(64'h0000_0000_4000_0000, 52'hA_AAAA_AAAA_A000);
    send_map(64'h0000_0080_0000_0000, 52'h0_0000_0001_0000);
  endtask

  task automatic test_misaligned();
    send_map(64'h0000_0000_0000_1001, 52'h0_0000_0000_3000);
    send_map(64'h0000_0000_0000_2000, 52'h0_0000_0000_0800);
    send_map(64'h0000_0000_0000_0FFF, 52'h0_0000_0000_0FFF);
    send_map(64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_base_relocation();
    // New tables wrap past the top of the physical space
    write_table_base(MAX_BASE);
    send_map(64'h0000_0200_0000_0000, 52'h0_0000_0000_7000);
    send_map(64'h0000_0200_0000_1000, 52'h0_0000_0000_8000);
    // Old pointers fall outside the store
    write_table_base(52'h0_0001_0000_0ABC);
    send_map(64'h0000_0000_0000_0000, 52'h0_0000_0000_9000);
    send_map(64'h0000_0200_0000_2000, 52'h0_0000_0000_A000);
    write_table_base('0);
    send_map(64'h0000_0000_0000_2000, 52'h0_0000_0000_B000);
  endtask

  task automatic test_pool_exhaustion();
    int k;
    for (k = 5; k <= 9; k++) send_map(VADDR_W'(k) << 39, 52'h0_0000_0000_C000);
    // Upper entries written before the pool ran dry stay
    send_map((VADDR_W'(5) << 39) | 64'h1000, 52'h0_0000_0000_D000);
    send_map((VADDR_W'(9) << 39) | 64'h1000, 52'h0_0000_0000_D000);
    send_map(64'h0000_0000_0000_3000, 52'h0_0000_0000_E000);
  endtask

  task automatic test_random_traffic(input int n);
    logic [VADDR_W-1:0] page;
    logic [PADDR_W-1:0] frame;
    int                 pick;
    int                 i;
    for (i = 0; i < n; i++) begin
      page  = {16'($urandom), pick_table_index(), pick_table_index(), pick_table_index(),
               IDX_W'($urandom), 12'h000};
      frame = {40'({$urandom, $urandom}), 12'h000};
      pick  = $urandom_range(0, 99);
      if (pick >= 97) begin
        page  = {$urandom, $urandom};
        frame = PADDR_W'({$urandom, $urandom});
      end else if (pick >= 92) begin
        page[PAGE_W-1:0] = PAGE_W'($urandom_range(1, 4095));
      end else if (pick >= 87) begin
        frame[PAGE_W-1:0] = PAGE_W'($urandom_range(1, 4095));
      end
      send_map(page, frame);
    end
  endtask

  // Check each status word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected done, expected none, actual status %0d", $time, status);
      end else begin
        expected_status = pending_status.pop_front();
        if (status !== expected_status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, expected_status, status);
        end
        case (expected_status)
          STATUS_OK:      count_ok++;
          STATUS_INVALID: count_inval++;
          default:        count_nofr++;
        endcase
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d status words outstanding",
               $time, cycle_count, pending_status.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [PADDR_W-1:0] base;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_data    <= '0;
    start       <= 1'b0;
    page_start  <= '0;
    frame_start <= '0;
    for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
    shadow_next = 1;
    shadow_base = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Low bits of table_base are ignored
    write_table_base(52'h0_0000_0000_0ABC);
    test_fresh_paths();
    test_misaligned();
    test_base_relocation();
    test_pool_exhaustion();

    test_random_traffic(900);
    write_table_base({PFN_W'($urandom_range(1, 8)), PAGE_W'($urandom)});
    test_random_traffic(250);
    write_table_base(MAX_BASE);
    test_random_traffic(250);
    base = PADDR_W'({$urandom, $urandom});
    if (base > MAX_BASE) base = MAX_BASE;
    write_table_base(base);
    test_random_traffic(100);
    write_table_base('0);
    test_random_traffic(450);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d status words: %0d mapped, %0d rejected, %0d out of frames",
             count_ok + count_inval + count_nofr, count_ok, count_inval, count_nofr);
    $display("Used %0d table_base settings and %0d of %0d store frames",
             base_writes, shadow_next, TABLE_FRAMES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
